@@ rtl/prb_pkg.sv @@
// ---------------------------------------------------------------------------
// Packet receive ring buffer package
// Shared types, codes and defaults for the packet receive ring buffer.
// ---------------------------------------------------------------------------
package prb_pkg;

    // Default ring depth in bytes.
    localparam int BUFFER_DEPTH_DEF = 128;

    // Register reset values.
    localparam logic [7:0] MAX_LEN_RESET = 8'd64;
    localparam logic [7:0] MIN_LEN_RESET = 8'd7;

    // Trailer bytes that the radio appends to the payload length.
    localparam logic [7:0] TRAILER_BYTES = 8'd2;

    // Configuration register indexes.
    localparam logic CFG_MAX_LEN = 1'b0;
    localparam logic CFG_MIN_LEN = 1'b1;

    // Item operation codes.
    localparam logic [1:0] FUNC_HEADER = 2'd0;
    localparam logic [1:0] FUNC_BODY   = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_NONE     = 3'd0;
    localparam logic [2:0] ST_ACCEPT   = 3'd1;
    localparam logic [2:0] ST_OVERFLOW = 3'd2;
    localparam logic [2:0] ST_BADLEN   = 3'd3;
    localparam logic [2:0] ST_FLUSHED  = 3'd4;
    localparam logic [2:0] ST_STORED   = 3'd5;
    localparam logic [2:0] ST_DROPPED  = 3'd6;

    // Input beat payload.
    typedef struct packed {
        logic [1:0] func;
        logic       rx_overflow;
        logic [7:0] data_byte;
    } in_item_t;

    // Output beat payload.
    typedef struct packed {
        logic [2:0] status;
        logic [7:0] read_data;
        logic       was_empty;
    } out_item_t;

    // Per-item result from the control unit, before the memory data joins it.
    typedef struct packed {
        logic [2:0] status;
        logic       was_empty;
        logic       is_read;
    } ctrl_result_t;

endpackage

@@ rtl/prb_ram.sv @@
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered, enabled read.
// ---------------------------------------------------------------------------
module prb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read; the data holds while the read is not enabled.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/prb_ctrl.sv @@
// ---------------------------------------------------------------------------
// Packet receive ring buffer control
// Holds the ring pointers and the pending body count, judges headers and
// drives the ring memory ports for each accepted beat.
// ---------------------------------------------------------------------------
module prb_ctrl #(
    parameter int BUFFER_DEPTH = prb_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  prb_pkg::in_item_t               item,
    input  logic [7:0]                      max_len,
    input  logic [7:0]                      min_len,
    output logic                            ram_we,
    output logic [$clog2(BUFFER_DEPTH)-1:0] ram_waddr,
    output logic [7:0]                      ram_wdata,
    output logic                            ram_re,
    output logic [$clog2(BUFFER_DEPTH)-1:0] ram_raddr,
    output prb_pkg::ctrl_result_t           result
);

    localparam int IDX_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W = IDX_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUFFER_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(BUFFER_DEPTH);

    logic [IDX_W-1:0] write_index_reg, write_index_next;
    logic [IDX_W-1:0] read_index_reg, read_index_next;
    logic [7:0]       pending_reg, pending_next;

    logic [CNT_W-1:0] w_ext, r_ext, free_cnt;
    logic [8:0]       free9, size9;
    logic [7:0]       size;
    logic [IDX_W-1:0] write_adv, read_adv;

    // Free space with one slot always kept empty.
    assign w_ext = {1'b0, write_index_reg};
    assign r_ext = {1'b0, read_index_reg};

    always_comb
    begin
        if (write_index_reg < read_index_reg)
        begin
            free_cnt = r_ext - w_ext - CNT_W'(1);
        end
        else
        begin
            free_cnt = DEPTH_C - w_ext + r_ext - CNT_W'(1);
        end
    end

    assign free9 = 9'(free_cnt);
    assign size  = item.data_byte + prb_pkg::TRAILER_BYTES;
    assign size9 = {1'b0, size};

    // Pointer increments wrap at the ring depth.
    assign write_adv = (write_index_reg == LAST_IDX) ? '0 : write_index_reg + IDX_W'(1);
    assign read_adv  = (read_index_reg == LAST_IDX) ? '0 : read_index_reg + IDX_W'(1);

    // Per-beat decision and next state.
    always_comb
    begin
        write_index_next = write_index_reg;
        read_index_next  = read_index_reg;
        pending_next     = pending_reg;
        ram_we           = 1'b0;
        ram_wdata        = item.data_byte;
        ram_re           = 1'b0;
        result.status    = prb_pkg::ST_NONE;
        result.was_empty = 1'b0;
        result.is_read   = 1'b0;

        if (accept)
        begin
            case (item.func)
                prb_pkg::FUNC_HEADER:
                begin
                    pending_next = '0;
                    if (item.rx_overflow)
                    begin
                        result.status = prb_pkg::ST_OVERFLOW;
                    end
                    else if (size >= max_len || size < min_len)
                    begin
                        result.status = prb_pkg::ST_BADLEN;
                    end
                    else if (free9 > size9)
                    begin
                        ram_we           = 1'b1;
                        ram_wdata        = size;
                        write_index_next = write_adv;
                        pending_next     = size;
                        result.status    = prb_pkg::ST_ACCEPT;
                    end
                    else
                    begin
                        write_index_next = '0;
                        read_index_next  = '0;
                        result.status    = prb_pkg::ST_FLUSHED;
                    end
                end
                prb_pkg::FUNC_BODY:
                begin
                    if (pending_reg != 8'd0)
                    begin
                        ram_we           = 1'b1;
                        write_index_next = write_adv;
                        pending_next     = pending_reg - 8'd1;
                        result.status    = prb_pkg::ST_STORED;
                    end
                    else
                    begin
                        result.status = prb_pkg::ST_DROPPED;
                    end
                end
                prb_pkg::FUNC_READ:
                begin
                    ram_re           = 1'b1;
                    read_index_next  = read_adv;
                    result.was_empty = (read_index_reg == write_index_reg);
                    result.is_read   = 1'b1;
                end
                default:
                begin
                    result.status = prb_pkg::ST_NONE;
                end
            endcase
        end
    end

    assign ram_waddr = write_index_reg;
    assign ram_raddr = read_index_reg;

    // Pointer and count registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_index_reg <= '0;
            read_index_reg  <= '0;
            pending_reg     <= '0;
        end
        else
        begin
            write_index_reg <= write_index_next;
            read_index_reg  <= read_index_next;
            pending_reg     <= pending_next;
        end
    end

endmodule

@@ rtl/packet_rx_ring_buffer_top.sv @@
// ---------------------------------------------------------------------------
// Packet receive ring buffer, top level
// Radio receive ring with packet admission, configuration registers and a
// registered result stage.
// ---------------------------------------------------------------------------
// The block takes one beat per clock cycle and returns exactly one result
// beat for each, in the cycle after acceptance. The rate is set by the ring
// memory, which sees at most one write or one registered read per beat, and
// by the single result register: a new beat is taken whenever that register
// is empty or is being emptied in the same cycle. Header beats judge the
// packet length against the limits and the free space, body beats fill the
// ring while bytes are expected, and read beats return the byte at the read
// pointer and always advance it. Entries that were never written read back
// with undefined contents. Configuration writes are accepted in every cycle.
// ---------------------------------------------------------------------------
module packet_rx_ring_buffer_top #(
    parameter int BUFFER_DEPTH = prb_pkg::BUFFER_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  prb_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output prb_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [7:0]         cfg_data
);

    localparam int IDX_W = $clog2(BUFFER_DEPTH);

    logic                  accept;
    logic [7:0]            max_len_reg, min_len_reg;
    logic                  out_valid_reg;
    logic [2:0]            status_reg;
    logic                  was_empty_reg;
    logic                  is_read_reg;
    prb_pkg::ctrl_result_t result;
    logic                  ram_we, ram_re;
    logic [IDX_W-1:0]      ram_waddr, ram_raddr;
    logic [7:0]            ram_wdata, ram_rdata;

    // Input handshake: hold off only while a result waits downstream.
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= prb_pkg::MAX_LEN_RESET;
            min_len_reg <= prb_pkg::MIN_LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                prb_pkg::CFG_MAX_LEN: max_len_reg <= cfg_data;
                prb_pkg::CFG_MIN_LEN: min_len_reg <= cfg_data;
                default:              max_len_reg <= max_len_reg;
            endcase
        end
    end

    // Pointer control and admission.
    prb_ctrl #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (in_data),
        .max_len   (max_len_reg),
        .min_len   (min_len_reg),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .result    (result)
    );

    // Ring storage.
    prb_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload; the memory read data is registered alongside.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= result.status;
            was_empty_reg <= result.was_empty;
            is_read_reg   <= result.is_read;
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_data.status    = status_reg;
    assign out_data.was_empty = was_empty_reg;
    assign out_data.read_data = is_read_reg ? ram_rdata : 8'd0;

endmodule
